>>> hdl/chtbl_pkg.sv
// chtbl_pkg: shared codes, widths and state types of the chained hash table
// no dependencies

package chtbl_pkg;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 9;
    localparam int DIV_STEPS = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_GET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_CHECK,
        BK_READ,
        BK_POP,
        BK_FINISH
    } back_state_t;

endpackage

>>> hdl/chtbl_ram.sv
// chtbl_ram: generic single write port, single read port ram with registered read
// no dependencies

module chtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/chtbl_queue.sv
// chtbl_queue: small register fifo between front and back
// no dependencies

module chtbl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/chtbl_front.sv
// chtbl_front: accepts requests and reduces the key to its bucket index
// depends on chtbl_pkg

module chtbl_front import chtbl_pkg::*; #(
    parameter int MAX_BUCKETS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       command,
    input  logic [KEY_W-1:0]       key,
    input  logic [VALUE_W-1:0]     value,
    input  logic [CFG_W-1:0]       bucket_count,
    input  logic                   clearing,
    output logic                   q_push,
    input  logic                   q_full,
    output logic [CMD_W-1:0]       q_cmd,
    output logic [KEY_W-1:0]       q_key,
    output logic [VALUE_W-1:0]     q_value,
    output logic [(MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1)-1:0] q_bucket
);

    localparam int BW = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int DW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = $clog2(KEY_W / DIV_STEPS);

    front_state_t         state_reg, state_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     shift_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [DW-1:0]        div_reg;
    logic [DW-1:0]        rem_reg, rem_step;
    logic [31:0]          cfg_ext, eff;
    logic                 accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != FR_IDLE) || clearing;
    assign q_cmd    = cmd_reg;
    assign q_key    = key_reg;
    assign q_value  = val_reg;
    assign q_bucket = rem_reg[BW-1:0];

    always_comb
    begin
        cfg_ext = 32'(bucket_count);
        if (cfg_ext == 32'd0)
        begin
            eff = 32'd1;
        end
        else if (cfg_ext > 32'(MAX_BUCKETS))
        begin
            eff = 32'(MAX_BUCKETS);
        end
        else
        begin
            eff = cfg_ext;
        end
    end

    // eight restoring steps per cycle, msb first
    always_comb
    begin
        logic [DW:0]   t;
        logic [DW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, shift_reg[KEY_W-1-i]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[DW-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    state_next = FR_DIV;
                    cnt_next   = '0;
                end
            end
            FR_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(KEY_W / DIV_STEPS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            shift_reg <= key;
            val_reg   <= value;
            div_reg   <= eff[DW-1:0];
            rem_reg   <= '0;
        end
        else if (state_reg == FR_DIV)
        begin
            shift_reg <= shift_reg << DIV_STEPS;
            rem_reg   <= rem_step;
        end
    end

endmodule

>>> hdl/chtbl_back.sv
// chtbl_back: walks bucket chains, updates nodes and the free pool, holds the result
// depends on chtbl_pkg and chtbl_ram

module chtbl_back import chtbl_pkg::*; #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_COUNT  = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   clearing,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic [CMD_W-1:0]       q_cmd,
    input  logic [KEY_W-1:0]       q_key,
    input  logic [VALUE_W-1:0]     q_value,
    input  logic [(MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1)-1:0] q_bucket,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [VALUE_W-1:0]     read_value
);

    localparam int BW = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    back_state_t          state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [BW-1:0]        bucket_reg, bucket_next;
    logic [LW-1:0]        node_reg, node_next;
    logic [LW-1:0]        prev_reg, prev_next;
    logic [LW-1:0]        head_saved_reg, head_saved_next;
    logic [LW-1:0]        fresh_reg, fresh_next;
    logic [LW-1:0]        sp_reg, sp_next, sp_dec;
    logic [BW-1:0]        clr_reg, clr_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;

    logic                 head_we;
    logic [BW-1:0]        head_waddr;
    logic [LW-1:0]        head_wdata, head_rdata;
    logic                 key_we, val_we, link_we, stack_we;
    logic [NW-1:0]        node_waddr, link_waddr;
    logic [LW-1:0]        link_wdata, link_rdata;
    logic [KEY_W-1:0]     key_rdata;
    logic [VALUE_W-1:0]   val_rdata;
    logic [NW-1:0]        stack_rdata;
    logic                 hit;
    logic                 alloc_en;
    logic [NW-1:0]        alloc_node;

    assign clearing   = state_reg == BK_CLEAR;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;
    assign sp_dec     = sp_reg - 1'b1;
    assign hit        = key_rdata == key_reg;

    chtbl_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(q_bucket), .rdata(head_rdata)
    );

    chtbl_ram #(.WIDTH(KEY_W), .DEPTH(NODE_COUNT)) u_key (
        .clk(clk), .we(key_we), .waddr(node_waddr), .wdata(key_reg),
        .raddr(node_reg[NW-1:0]), .rdata(key_rdata)
    );

    chtbl_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_COUNT)) u_value (
        .clk(clk), .we(val_we), .waddr(node_waddr), .wdata(val_reg),
        .raddr(node_reg[NW-1:0]), .rdata(val_rdata)
    );

    chtbl_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(node_reg[NW-1:0]), .rdata(link_rdata)
    );

    chtbl_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free (
        .clk(clk), .we(stack_we), .waddr(sp_reg[NW-1:0]), .wdata(node_reg[NW-1:0]),
        .raddr(sp_dec[NW-1:0]), .rdata(stack_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        bucket_next     = bucket_reg;
        node_next       = node_reg;
        prev_next       = prev_reg;
        head_saved_next = head_saved_reg;
        fresh_next      = fresh_reg;
        sp_next         = sp_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        q_pop           = 1'b0;
        head_we         = 1'b0;
        head_waddr      = bucket_reg;
        head_wdata      = link_rdata;
        key_we          = 1'b0;
        val_we          = 1'b0;
        link_we         = 1'b0;
        stack_we        = 1'b0;
        node_waddr      = node_reg[NW-1:0];
        link_waddr      = prev_reg[NW-1:0];
        link_wdata      = link_rdata;
        alloc_en        = 1'b0;
        alloc_node      = fresh_reg[NW-1:0];
        case (state_reg)
            BK_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NULL_LINK;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BW'(MAX_BUCKETS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    key_next       = q_key;
                    val_next       = q_value;
                    bucket_next    = q_bucket;
                    res_value_next = '0;
                    if (q_cmd == CMD_NONE)
                    begin
                        res_status_next = ST_MISS;
                        state_next      = BK_FINISH;
                    end
                    else
                    begin
                        state_next = BK_HEAD;
                    end
                end
            end
            BK_HEAD:
            begin
                node_next       = head_rdata;
                head_saved_next = head_rdata;
                prev_next       = NULL_LINK;
                state_next      = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (node_reg == NULL_LINK)
                begin
                    state_next      = BK_FINISH;
                    res_status_next = ST_MISS;
                    if (cmd_reg == CMD_SET)
                    begin
                        if (fresh_reg != NULL_LINK)
                        begin
                            // never used nodes go first
                            alloc_en        = 1'b1;
                            alloc_node      = fresh_reg[NW-1:0];
                            fresh_next      = fresh_reg + 1'b1;
                            res_status_next = ST_NEW;
                        end
                        else if (sp_reg != '0)
                        begin
                            state_next = BK_POP;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
                else
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (hit)
                begin
                    res_status_next = ST_FOUND;
                    state_next      = BK_FINISH;
                    case (cmd_reg)
                        CMD_GET:
                        begin
                            res_value_next = val_rdata;
                        end
                        CMD_SET:
                        begin
                            val_we = 1'b1;
                        end
                        CMD_DEL:
                        begin
                            if (prev_reg == NULL_LINK)
                            begin
                                head_we = 1'b1;
                            end
                            else
                            begin
                                link_we = 1'b1;
                            end
                            stack_we = 1'b1;
                            sp_next  = sp_reg + 1'b1;
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
                else
                begin
                    prev_next  = node_reg;
                    node_next  = link_rdata;
                    state_next = BK_CHECK;
                end
            end
            BK_POP:
            begin
                alloc_en        = 1'b1;
                alloc_node      = stack_rdata;
                sp_next         = sp_dec;
                res_status_next = ST_NEW;
                state_next      = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // link a new node at the head of its chain
        if (alloc_en)
        begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            link_we    = 1'b1;
            node_waddr = alloc_node;
            link_waddr = alloc_node;
            link_wdata = head_saved_reg;
            head_we    = 1'b1;
            head_waddr = bucket_reg;
            head_wdata = LW'(alloc_node);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            fresh_reg     <= '0;
            sp_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            sp_reg        <= sp_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        bucket_reg     <= bucket_next;
        node_reg       <= node_next;
        prev_reg       <= prev_next;
        head_saved_reg <= head_saved_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && !q_empty)
        else $error("queue popped outside idle");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg <= NULL_LINK) && (sp_reg <= fresh_reg))
        else $error("free pool count out of range");

    a_delete_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ && hit && cmd_reg == CMD_DEL)
        |=> sp_reg == $past(sp_reg) + 1'b1)
        else $error("deleted node not returned to pool");

    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FINISH && (!out_valid_reg || !out_stall))
        |=> out_valid_reg && state_reg == BK_IDLE)
        else $error("result not loaded");

endmodule

>>> hdl/chained_hash_table.sv
// chained_hash_table: top level of the separate chaining key-value table
// flow: the front reduces the key modulo the bucket count in its divider, then pushes to the queue;
// the back pops it, reads the bucket head, checks and reads each chain node visited, and passes
// through a pop state as well when a set takes a node back from the free stack; the front takes a new
// request once the last is queued, even while the back still walks its chain; the walk is bound by the
// registered read of the node memories. reset: asynchronous, active low; a clearing pass writes the
// null link to all MAX_BUCKETS bucket heads while in_stall stays high, configuration writes are taken throughout

module chained_hash_table import chtbl_pkg::*; #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_COUNT  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [CFG_W-1:0]    cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  read_value
);

    localparam int BW      = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW      = CMD_W + KEY_W + VALUE_W + BW;
    localparam int Q_DEPTH = 2;

    logic [CFG_W-1:0]   bucket_count_reg;
    logic               clearing;
    logic               q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0]   f_cmd, b_cmd;
    logic [KEY_W-1:0]   f_key, b_key;
    logic [VALUE_W-1:0] f_value, b_value;
    logic [BW-1:0]      f_bucket, b_bucket;
    logic [QW-1:0]      q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            bucket_count_reg <= cfg_write_data;
        end
    end

    chtbl_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .key(key), .value(value),
        .bucket_count(bucket_count_reg), .clearing(clearing),
        .q_push(q_push), .q_full(q_full),
        .q_cmd(f_cmd), .q_key(f_key), .q_value(f_value), .q_bucket(f_bucket)
    );

    assign q_in = {f_cmd, f_key, f_value, f_bucket};
    assign {b_cmd, b_key, b_value, b_bucket} = q_out;

    chtbl_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    chtbl_back #(.MAX_BUCKETS(MAX_BUCKETS), .NODE_COUNT(NODE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .clearing(clearing),
        .q_empty(q_empty), .q_pop(q_pop),
        .q_cmd(b_cmd), .q_key(b_key), .q_value(b_value), .q_bucket(b_bucket),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_value(read_value)
    );

endmodule
